[rtl/cplc_pkg.sv]
// Package for the canonical prefix line classifier.
// Holds request, register and order codes, payload structs and fixed constants.
// No dependencies.
package cplc_pkg;

  // default size of the key store
  localparam int KEY_DEPTH_DEF = 64;

  localparam logic [7:0] NEWLINE_BYTE = 8'd10;
  localparam logic [7:0] CASE_GAP     = 8'd32;   // 'a' - 'A'

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_KEY   = 2'd1,
    REQ_TEXT  = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    CFG_FOLD = 2'd0,
    CFG_DICT = 2'd1,
    CFG_CUT  = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ORD_KEY_BEFORE  = 3'd0,
    ORD_KEY_PREFIX  = 3'd1,
    ORD_EQUAL       = 3'd2,
    ORD_LINE_PREFIX = 3'd3,
    ORD_KEY_AFTER   = 3'd4
  } order_t;

  // canonicalizer settings
  typedef struct packed {
    logic       fold_case;
    logic       dictionary_order;
    logic [7:0] cut_char;
  } canon_cfg_t;

  // canonicalizer verdict for one byte
  typedef struct packed {
    logic       is_end;   // byte ends the compared part
    logic       keep;     // byte survives dictionary filtering
    logic [7:0] value;    // canonical byte
  } canon_t;

  // one result transaction
  typedef struct packed {
    logic [2:0] order;
    logic       is_match;
  } res_t;

endpackage

[rtl/cplc_if.sv]
// Valid/ready stream interfaces for the classifier request and result channels.
// Depends on nothing; payload widths are the fixed field widths.
interface cplc_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] data_byte;

  modport source (output valid, output req_type, output data_byte, input ready);
  modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

interface cplc_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] order;
  logic       is_match;

  modport source (output valid, output order, output is_match, input ready);
  modport sink   (input valid, input order, input is_match, output ready);
endinterface

[rtl/cplc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cplc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/cplc_canon.sv]
// Byte canonicalizer: end detection, dictionary filter and case folding.
// Depends on cplc_pkg.
module cplc_canon (
  input  logic [7:0]           data_byte,
  input  cplc_pkg::canon_cfg_t cfg,
  output cplc_pkg::canon_t     canon
);

  logic upper;
  logic lower;
  logic digit;

  // character classes, ASCII only
  assign upper = (data_byte >= 8'h41) && (data_byte <= 8'h5a);
  assign lower = (data_byte >= 8'h61) && (data_byte <= 8'h7a);
  assign digit = (data_byte >= 8'h30) && (data_byte <= 8'h39);

  assign canon.is_end = (data_byte == 8'd0) ||
                        ((cfg.cut_char != 8'd0) && (data_byte == cfg.cut_char));
  assign canon.keep   = !cfg.dictionary_order || upper || lower || digit;
  assign canon.value  = (cfg.fold_case && upper) ? data_byte + cplc_pkg::CASE_GAP
                                                 : data_byte;

endmodule

[rtl/cplc_out_buf.sv]
// Result output register with one skid entry.
// Depends on cplc_pkg and cplc_res_if.
module cplc_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  cplc_pkg::res_t     push_data,
  output logic               can_push,
  cplc_res_if.source         res
);

  logic           out_valid;
  cplc_pkg::res_t out_data;
  logic           skid_valid;
  cplc_pkg::res_t skid_data;
  logic           pop;

  assign pop      = out_valid && res.ready;
  assign can_push = !skid_valid;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop && skid_valid) begin
      skid_valid <= 1'b0;
    end else if (pop || !out_valid) begin
      out_valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (pop && skid_valid) begin
      out_data <= skid_data;
    end else if (pop || !out_valid) begin
      out_data <= push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  assign res.valid    = out_valid;
  assign res.order    = out_data.order;
  assign res.is_match = out_data.is_match;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while output register empty");
`endif

endmodule

[rtl/canonical_prefix_line_classifier_core.sv]
// Canonical prefix line classifier, top level.
// Uses cplc_pkg, cplc_if, cplc_canon, cplc_ram and cplc_out_buf.
//
// Usage:
//   req: request transactions (req_type, data_byte). Clear key, append a key
//        byte, or stream a dictionary text byte. A newline text byte closes
//        the line and produces one res transaction; nothing else does.
//   res: order of the key against the finished line and the is_match flag.
//   cfg_we/cfg_index/cfg_data: register writes (fold case, dictionary order,
//        cut character); the user writes them only while idle (not enforced).
// Throughput: one request per cycle while req.ready is high. Each byte is
//   handled in the cycle it is accepted against the key byte prefetched
//   from the key RAM, whose read address is the next match position.
// Latency: a result reaches the output register the cycle after its newline
//   is accepted, unless an earlier result still waits there for the receiver.
// Stall: the output register plus one skid entry absorb results; req.ready
//   drops only when both hold results the receiver has not taken.
// Reset: key empty, line state cleared, registers zero. The key RAM is not
//   cleared; only entries below the key length are ever compared.
module canonical_prefix_line_classifier_core #(
  parameter int KEY_DEPTH = cplc_pkg::KEY_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  cplc_req_if.sink   req,
  cplc_res_if.source res
);

  localparam int AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int LW = $clog2(KEY_DEPTH + 1);

  cplc_pkg::canon_cfg_t cfg;
  cplc_pkg::canon_t     canon;

  logic [LW-1:0]    key_length,  key_length_next;
  logic             key_closed,  key_closed_next;
  logic [LW-1:0]    match_position, match_position_next;
  logic             line_decided, line_decided_next;
  cplc_pkg::order_t decided_order, decided_order_next;
  logic             line_closed, line_closed_next;

  logic             accept;
  logic             can_push;
  logic             push;
  cplc_pkg::res_t   push_data;
  cplc_pkg::order_t line_order;

  logic             key_we;
  logic [7:0]       ram_q;
  logic             bypass;
  logic [7:0]       bypass_data;
  logic [7:0]       key_byte;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cplc_pkg::cfg_idx_t'(cfg_index))
        cplc_pkg::CFG_FOLD: cfg.fold_case        <= cfg_data[0];
        cplc_pkg::CFG_DICT: cfg.dictionary_order <= cfg_data[0];
        cplc_pkg::CFG_CUT:  cfg.cut_char         <= cfg_data;
        default: ;
      endcase
    end
  end

  cplc_canon u_canon (
    .data_byte (req.data_byte),
    .cfg       (cfg),
    .canon     (canon)
  );

  assign accept    = req.valid && req.ready;
  assign req.ready = can_push;

  // key byte at the match position: RAM prefetch, or registered write bypass
  assign key_byte = bypass ? bypass_data : ram_q;

  // order of a line ending now
  always_comb begin
    if (line_decided) begin
      line_order = decided_order;
    end else if (match_position >= key_length) begin
      line_order = cplc_pkg::ORD_EQUAL;
    end else begin
      line_order = cplc_pkg::ORD_LINE_PREFIX;
    end
  end

  // per-transaction state update
  always_comb begin
    key_length_next     = key_length;
    key_closed_next     = key_closed;
    match_position_next = match_position;
    line_decided_next   = line_decided;
    decided_order_next  = decided_order;
    line_closed_next    = line_closed;
    key_we              = 1'b0;
    push                = 1'b0;
    push_data.order     = line_order;
    push_data.is_match  = (line_order == cplc_pkg::ORD_KEY_PREFIX) ||
                          (line_order == cplc_pkg::ORD_EQUAL);
    if (accept) begin
      unique case (cplc_pkg::req_t'(req.req_type))
        cplc_pkg::REQ_CLEAR: begin
          key_length_next     = '0;
          key_closed_next     = 1'b0;
          match_position_next = '0;
          line_decided_next   = 1'b0;
          decided_order_next  = cplc_pkg::ORD_KEY_BEFORE;
          line_closed_next    = 1'b0;
        end
        cplc_pkg::REQ_KEY: begin
          if (!key_closed) begin
            if (canon.is_end) begin
              key_closed_next = 1'b1;
            end else if (canon.keep && (key_length < LW'(KEY_DEPTH))) begin
              key_we          = 1'b1;
              key_length_next = key_length + LW'(1);
            end
          end
        end
        cplc_pkg::REQ_TEXT: begin
          if (req.data_byte == cplc_pkg::NEWLINE_BYTE) begin
            push                = 1'b1;
            match_position_next = '0;
            line_decided_next   = 1'b0;
            decided_order_next  = cplc_pkg::ORD_KEY_BEFORE;
            line_closed_next    = 1'b0;
          end else if (!line_closed && !line_decided) begin
            if (canon.is_end) begin
              line_closed_next = 1'b1;
            end else if (canon.keep) begin
              if (match_position >= key_length) begin
                line_decided_next  = 1'b1;
                decided_order_next = cplc_pkg::ORD_KEY_PREFIX;
              end else if (key_byte == canon.value) begin
                match_position_next = match_position + LW'(1);
              end else begin
                line_decided_next  = 1'b1;
                decided_order_next = (key_byte < canon.value) ? cplc_pkg::ORD_KEY_BEFORE
                                                              : cplc_pkg::ORD_KEY_AFTER;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // state registers and read bypass
  always_ff @(posedge clk) begin
    if (rst) begin
      key_length     <= '0;
      key_closed     <= 1'b0;
      match_position <= '0;
      line_decided   <= 1'b0;
      decided_order  <= cplc_pkg::ORD_KEY_BEFORE;
      line_closed    <= 1'b0;
      bypass         <= 1'b0;
    end else begin
      key_length     <= key_length_next;
      key_closed     <= key_closed_next;
      match_position <= match_position_next;
      line_decided   <= line_decided_next;
      decided_order  <= decided_order_next;
      line_closed    <= line_closed_next;
      bypass         <= key_we && (key_length[AW-1:0] == match_position_next[AW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    bypass_data <= canon.value;
  end

  cplc_ram #(
    .WIDTH (8),
    .DEPTH (KEY_DEPTH),
    .AW    (AW)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_length[AW-1:0]),
    .wdata (canon.value),
    .raddr (match_position_next[AW-1:0]),
    .rdata (ram_q)
  );

  cplc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .can_push  (can_push),
    .res       (res)
  );

`ifndef SYNTHESIS
  a_key_len_bound: assert property (@(posedge clk) disable iff (rst)
    key_length <= LW'(KEY_DEPTH))
    else $error("key length beyond key store");

  a_match_bound: assert property (@(posedge clk) disable iff (rst)
    match_position <= key_length)
    else $error("match position beyond key length");

  a_newline_result: assert property (@(posedge clk) disable iff (rst)
    accept && (req.req_type == cplc_pkg::REQ_TEXT) &&
    (req.data_byte == cplc_pkg::NEWLINE_BYTE) |=> res.valid)
    else $error("newline accepted without a result");

  a_decided_order: assert property (@(posedge clk) disable iff (rst)
    line_decided |-> (decided_order == cplc_pkg::ORD_KEY_BEFORE) ||
                     (decided_order == cplc_pkg::ORD_KEY_PREFIX) ||
                     (decided_order == cplc_pkg::ORD_KEY_AFTER))
    else $error("decided line holds an order only a newline can give");
`endif

endmodule

[bench/cplc_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the canonical prefix line classifier: watches config writes and both
// stream channels, predicts the order of each text line and compares results in order.
// Depends on cplc_pkg and cplc_if.
module cplc_checker #(
  parameter int KEY_DEPTH = cplc_pkg::KEY_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  cplc_req_if        req_mon,
  cplc_res_if        res_mon,
  output int         fails,
  output int         pending
);

  // predictor state
  logic [7:0]       key_bytes [KEY_DEPTH];
  int unsigned      key_len;
  logic             key_closed;
  int unsigned      match_pos;
  logic             line_decided;
  cplc_pkg::order_t decided_ord;
  logic             line_closed;

  // register copies
  logic        fold_on;
  logic        dict_on;
  logic [7:0]  cut_byte;

  cplc_pkg::res_t order_q [$];
  int             fail_cnt;

  // zero or the active cut byte ends the compared part
  function automatic logic stop_byte(input logic [7:0] b);
    return b == 8'd0 || (cut_byte != 8'd0 && b == cut_byte);
  endfunction

  // dictionary filter and case folding; kept = 0 means the byte is dropped
  function automatic void normalize(input logic [7:0] b, output logic kept,
                                    output logic [7:0] c);
    logic upper;
    logic alnum;
    upper = b >= "A" && b <= "Z";
    alnum = upper || (b >= "a" && b <= "z") || (b >= "0" && b <= "9");
    kept  = !dict_on || alnum;
    c     = (fold_on && upper) ? b + cplc_pkg::CASE_GAP : b;
  endfunction

  task automatic restart_line();
    match_pos    = 0;
    line_decided = 1'b0;
    decided_ord  = cplc_pkg::ORD_KEY_BEFORE;
    line_closed  = 1'b0;
  endtask

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("MISMATCH @%0t: %s got %0d expected %0d", $time, what, got, want);
    fail_cnt++;
  endtask

  // advance the line state for one accepted request transaction
  task automatic classify_request(input logic [1:0] rt, input logic [7:0] b);
    logic             kept;
    logic [7:0]       c;
    cplc_pkg::order_t ord;
    cplc_pkg::res_t   exp;
    case (rt)
      cplc_pkg::REQ_CLEAR: begin
        key_len    = 0;
        key_closed = 1'b0;
        restart_line();
      end
      cplc_pkg::REQ_KEY: begin
        if (!key_closed) begin
          if (stop_byte(b)) begin
            key_closed = 1'b1;
          end else begin
            normalize(b, kept, c);
            if (kept && key_len < KEY_DEPTH) begin
              key_bytes[key_len] = c;
              key_len++;
            end
          end
        end
      end
      cplc_pkg::REQ_TEXT: begin
        if (b == cplc_pkg::NEWLINE_BYTE) begin
          if (line_decided)
            ord = decided_ord;
          else if (match_pos >= key_len)
            ord = cplc_pkg::ORD_EQUAL;
          else
            ord = cplc_pkg::ORD_LINE_PREFIX;
          exp.order    = ord;
          exp.is_match = (ord == cplc_pkg::ORD_KEY_PREFIX || ord == cplc_pkg::ORD_EQUAL);
          order_q.push_back(exp);
          restart_line();
        end else if (!line_closed && !line_decided) begin
          if (stop_byte(b)) begin
            line_closed = 1'b1;
          end else begin
            normalize(b, kept, c);
            if (kept) begin
              // line ran past the key: key is a proper prefix
              if (match_pos >= key_len) begin
                line_decided = 1'b1;
                decided_ord  = cplc_pkg::ORD_KEY_PREFIX;
              end else if (key_bytes[match_pos] == c) begin
                match_pos++;
              end else begin
                line_decided = 1'b1;
                decided_ord  = (key_bytes[match_pos] < c) ? cplc_pkg::ORD_KEY_BEFORE
                                                          : cplc_pkg::ORD_KEY_AFTER;
              end
            end
          end
        end
      end
      default: ;  // unused request code is ignored
    endcase
  endtask

  task automatic check_result(input logic [2:0] got_ord, input logic got_match);
    cplc_pkg::res_t exp;
    if (order_q.size() == 0) begin
      report("result with no line pending, order", 8'(got_ord), 8'd0);
    end else begin
      exp = order_q.pop_front();
      if (got_ord !== exp.order)
        report("order", 8'(got_ord), 8'(exp.order));
      if (got_match !== exp.is_match)
        report("is_match", 8'(got_match), 8'(exp.is_match));
    end
  endtask

  // results are checked before the request of the same edge is predicted
  always @(posedge clk) begin
    if (rst) begin
      key_len    = 0;
      key_closed = 1'b0;
      restart_line();
      fold_on    = 1'b0;
      dict_on    = 1'b0;
      cut_byte   = 8'd0;
      fail_cnt   = 0;
      order_q.delete();
    end else begin
      if (res_mon.valid && res_mon.ready)
        check_result(res_mon.order, res_mon.is_match);
      if (cfg_we) begin
        case (cfg_index)
          cplc_pkg::CFG_FOLD: fold_on  = cfg_data[0];
          cplc_pkg::CFG_DICT: dict_on  = cfg_data[0];
          cplc_pkg::CFG_CUT:  cut_byte = cfg_data;
          default: ;
        endcase
      end
      if (req_mon.valid && req_mon.ready)
        classify_request(req_mon.req_type, req_mon.data_byte);
    end
    pending <= order_q.size();
    fails   <= fail_cnt;
  end

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// Top of the classifier bench: clock, reset, request and result traffic, config phases.
// Depends on cplc_pkg, cplc_if, canonical_prefix_line_classifier_core and cplc_checker.
module testbench;

  localparam int IDLE_LIMIT  = 2000;
  localparam int ITEM_TARGET = 1750;
  localparam int NUM_PHASES  = 10;
  localparam int SETTLE      = 4;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;
  int         fails;
  int         pending;

  cplc_req_if req_ch ();
  cplc_res_if res_ch ();

  int         sent;
  logic       req_idle_on;
  logic       res_stall_on;
  int         stall_left;
  logic [7:0] cut_now;
  logic [7:0] key_raw [$];

  canonical_prefix_line_classifier_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .res       (res_ch)
  );

  cplc_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_mon   (req_ch),
    .res_mon   (res_ch),
    .fails     (fails),
    .pending   (pending)
  );

  always #10 clk = ~clk;

  // idle length: mostly short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 1;
    if (r < 92) return $urandom_range(2, 4);
    return $urandom_range(10, 40);
  endfunction

  // byte mix weighted toward letters, digits and the bytes that end a field
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(99);
    if (r < 25) return 8'($urandom_range(97, 122));
    if (r < 45) return 8'($urandom_range(65, 90));
    if (r < 58) return 8'($urandom_range(48, 57));
    if (r < 70) return 8'($urandom_range(32, 47));
    if (r < 80) return 8'($urandom_range(128, 255));
    if (r < 83) return cut_now;
    if (r < 85) return 8'd0;
    if (r < 87) return cplc_pkg::NEWLINE_BYTE;
    return 8'($urandom_range(255));
  endfunction

  // result side back-pressure
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      res_ch.ready <= 1'b0;
    end else if (res_stall_on && $urandom_range(99) < 20) begin
      stall_left = pick_gap() - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // one request transaction, with an optional idle gap ahead of it
  task automatic send_item(input logic [1:0] rt, input logic [7:0] b);
    int gap;
    gap = (req_idle_on && $urandom_range(99) < 30) ? pick_gap() : 0;
    repeat (gap) @(negedge clk) req_ch.valid <= 1'b0;
    @(negedge clk);
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= rt;
    req_ch.data_byte <= b;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_str(input logic [1:0] rt, input string s);
    for (int i = 0; i < s.len(); i++) send_item(rt, s[i]);
  endtask

  // stop sending until every line has been answered and the pipe is quiet
  task automatic drain();
    @(negedge clk) req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input cplc_pkg::cfg_idx_t idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
  endtask

  task automatic set_mode(input logic fold, input logic dict, input logic [7:0] cut);
    write_reg(cplc_pkg::CFG_FOLD, {7'd0, fold});
    write_reg(cplc_pkg::CFG_DICT, {7'd0, dict});
    write_reg(cplc_pkg::CFG_CUT, cut);
    @(negedge clk) cfg_we <= 1'b0;
    cut_now = cut;
  endtask

  // new key: mostly short, sometimes longer than the key store
  task automatic load_key();
    int         n;
    logic [7:0] b;
    send_item(cplc_pkg::REQ_CLEAR, 8'($urandom_range(255)));
    key_raw.delete();
    n = ($urandom_range(99) < 8) ? $urandom_range(60, 72) : $urandom_range(0, 8);
    repeat (n) begin
      b = pick_byte();
      key_raw.push_back(b);
      send_item(cplc_pkg::REQ_KEY, b);
    end
    // explicit end of key, then a byte that must be ignored
    if ($urandom_range(99) < 20) begin
      send_item(cplc_pkg::REQ_KEY, (cut_now != 8'd0 && $urandom_range(1)) ? cut_now : 8'd0);
      send_item(cplc_pkg::REQ_KEY, pick_byte());
    end
  endtask

  // line from the key: exact, cut short, extended, altered, unrelated or end byte added
  task automatic send_line();
    logic [7:0] ln [$];
    int         kind;
    int         n;
    logic [7:0] b;
    kind = $urandom_range(5);
    foreach (key_raw[i]) begin
      b = key_raw[i];
      if (((b >= "a" && b <= "z") || (b >= "A" && b <= "Z")) && $urandom_range(99) < 30)
        b = b ^ cplc_pkg::CASE_GAP;
      ln.push_back(b);
    end
    case (kind)
      1: begin
        n = (ln.size() == 0) ? 0 : $urandom_range(ln.size() - 1);
        while (ln.size() > n) void'(ln.pop_back());
      end
      2: repeat ($urandom_range(1, 4)) ln.push_back(pick_byte());
      3: if (ln.size() != 0) ln[$urandom_range(ln.size() - 1)] = pick_byte();
      4: begin
        ln.delete();
        repeat ($urandom_range(10)) ln.push_back(pick_byte());
      end
      5: ln.insert($urandom_range(ln.size()), (cut_now != 8'd0) ? cut_now : 8'd0);
      default: ;
    endcase
    foreach (ln[i]) begin
      // key grows or is cleared in the middle of a line
      if ($urandom_range(99) < 3) begin
        b = pick_byte();
        key_raw.push_back(b);
        send_item(cplc_pkg::REQ_KEY, b);
      end else if ($urandom_range(199) == 0) begin
        key_raw.delete();
        send_item(cplc_pkg::REQ_CLEAR, 8'd0);
      end
      send_item(cplc_pkg::REQ_TEXT, ln[i]);
    end
    send_item(cplc_pkg::REQ_TEXT, cplc_pkg::NEWLINE_BYTE);
  endtask

  // watchdog: too long without any transaction on either channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int       phase_end;
    logic     fold;
    logic     dict;
    logic [7:0] cut;
    req_ch.valid     = 1'b0;
    req_ch.req_type  = cplc_pkg::REQ_CLEAR;
    req_ch.data_byte = 8'd0;
    res_ch.ready     = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = cplc_pkg::CFG_FOLD;
    cfg_data         = 8'd0;
    sent             = 0;
    req_idle_on      = 1'b0;
    res_stall_on     = 1'b0;
    stall_left       = 0;
    cut_now          = 8'd0;
    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed: empty key, each order, extreme bytes, zero end byte, unused request
    send_str(cplc_pkg::REQ_TEXT, "x\n");
    send_item(cplc_pkg::REQ_CLEAR, 8'd0);
    send_str(cplc_pkg::REQ_KEY, "Ab");
    send_str(cplc_pkg::REQ_TEXT, "ab\n");
    send_str(cplc_pkg::REQ_TEXT, "Ab\n");
    send_str(cplc_pkg::REQ_TEXT, "A\n");
    send_str(cplc_pkg::REQ_TEXT, "Abc\n");
    send_item(cplc_pkg::REQ_TEXT, 8'hFF);
    send_item(cplc_pkg::REQ_TEXT, cplc_pkg::NEWLINE_BYTE);
    send_item(cplc_pkg::REQ_TEXT, 8'h00);
    send_str(cplc_pkg::REQ_TEXT, "A\n");
    send_item(2'd3, cplc_pkg::NEWLINE_BYTE);
    send_item(cplc_pkg::REQ_KEY, 8'h00);
    send_str(cplc_pkg::REQ_TEXT, "!\n");

    // random phases, each under its own register setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      fold = p[0];
      dict = p[1];
      case (p)
        4:       cut = 8'd255;
        5:       cut = cplc_pkg::NEWLINE_BYTE;
        6:       cut = 8'd9;
        7:       cut = "a";
        8, 9: begin
          fold = $urandom_range(1);
          dict = $urandom_range(1);
          cut  = ($urandom_range(1)) ? 8'($urandom_range(255)) : 8'($urandom_range(32, 126));
        end
        default: cut = 8'd0;
      endcase
      set_mode(fold, dict, cut);
      req_idle_on  = p % 3 != 0;
      res_stall_on = p % 4 != 1;
      phase_end    = sent + (ITEM_TARGET - sent) / (NUM_PHASES - p);
      load_key();
      while (sent < phase_end) begin
        if ($urandom_range(99) < 5) req_idle_on = ~req_idle_on;
        if ($urandom_range(99) < 5) res_stall_on = ~res_stall_on;
        if ($urandom_range(99) < 2) drain();
        if ($urandom_range(99) < 85) begin
          if ($urandom_range(99) < 30) load_key();
          repeat ($urandom_range(1, 4)) send_line();
        end else begin
          // noise: any request code and byte
          repeat ($urandom_range(1, 6))
            send_item(2'($urandom_range(3)), 8'($urandom_range(255)));
        end
      end
    end
    drain();

    if (fails == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
